/* rtl/core/pts_pkg.sv */
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the periodic task and timer scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int unsigned NUM_TASKS   = 16;
  localparam int unsigned NUM_TIMERS  = 16;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned MAX_RESULTS = 16;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned HANDLE_W = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned TASK_IW  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned TIMER_IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned TASK_CW  = $clog2(NUM_TASKS + 1);
  localparam int unsigned TIMER_CW = $clog2(NUM_TIMERS + 1);
  localparam int unsigned MAX_SLOTS = (NUM_TASKS > NUM_TIMERS) ? NUM_TASKS : NUM_TIMERS;
  localparam int unsigned WALK_W   = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CMP_W    = ((WALK_W > HANDLE_W) ? WALK_W : HANDLE_W) + 1;
  localparam int unsigned RES_CW   = $clog2(MAX_RESULTS + 1);

  localparam int unsigned S_DATA_W = ((HANDLE_W + VALUE_W + 1 + 7) / 8) * 8;
  localparam int unsigned M_DATA_W = ((HANDLE_W + 1 + STATUS_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK      = 3'd0,
    FN_STEP      = 3'd1,
    FN_REG_TASK  = 3'd2,
    FN_SET_RELD  = 3'd3,
    FN_SET_EN    = 3'd4,
    FN_REG_TIMER = 3'd5,
    FN_SET_TIMER = 3'd6,
    FN_QRY_TIMER = 3'd7
  } pts_func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BADH = 2'd2
  } pts_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TK_RD,
    S_TK_EX,
    S_TM_RD,
    S_TM_EX,
    S_ST_RD,
    S_ST_EX,
    S_ST_END,
    S_Q_EX,
    S_RESP
  } pts_state_e;

  typedef struct packed {
    logic                   reload_sel;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [COUNT_WIDTH-1:0] reload;
  } pts_cnt_op_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] next;
    logic                   zero;
  } pts_cnt_res_t;

endpackage

/* rtl/core/periodic_task_and_timer_scheduler_core.sv */
// ----------------------------------------------------------------------------
// periodic_task_and_timer_scheduler_core
// Periodic task table and one-shot timer bank walked by a shared count unit.
//
// channel  | dir | tdata (lsb first)                 | tuser | tlast
// s_axis   | in  | handle[4:0] value[36:5] enable[37]| func  | -
// m_axis   | out | result_handle[4:0] expired[5]     | -     | last
//          |     | status[7:6]                       |       |
//
// tick: walks every registered task slot and then every timer slot, each slot
//   through the registered slot memory read and then the count unit
// step: walks the task slots plus output stalls; query reads its timer; others go to the reply
// s_axis_tready is high only while no command is in flight
// reset clears the registered task and timer counts, enables and slot valid bits at once
// ----------------------------------------------------------------------------
module periodic_task_and_timer_scheduler_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // handle, value, enable, zero pad
  input  logic [pts_pkg::S_DATA_W-1:0] s_axis_tdata,
  // func
  input  logic [pts_pkg::FUNC_W-1:0]   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // result_handle, expired, status
  output logic [pts_pkg::M_DATA_W-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);

  localparam int unsigned CW  = pts_pkg::COUNT_WIDTH;
  localparam int unsigned HW  = pts_pkg::HANDLE_W;
  localparam int unsigned SW  = pts_pkg::STATUS_W;
  localparam int unsigned NT  = pts_pkg::NUM_TASKS;
  localparam int unsigned NM  = pts_pkg::NUM_TIMERS;
  localparam int unsigned TIW = pts_pkg::TASK_IW;
  localparam int unsigned MIW = pts_pkg::TIMER_IW;
  localparam int unsigned WW  = pts_pkg::WALK_W;
  localparam int unsigned CPW = pts_pkg::CMP_W;
  localparam int unsigned RW  = pts_pkg::RES_CW;

  // input fields
  pts_pkg::pts_func_e in_func;
  logic [HW-1:0]      in_hdl;
  logic [CW-1:0]      in_val;
  logic               in_en;
  logic               accept;

  assign in_func = pts_pkg::pts_func_e'(s_axis_tuser);
  assign in_hdl  = s_axis_tdata[HW-1:0];
  assign in_val  = s_axis_tdata[HW+CW-1:HW];
  assign in_en   = s_axis_tdata[HW+pts_pkg::VALUE_W];

  pts_pkg::pts_state_e state_q, state_d;

  logic [WW-1:0]              idx_q;
  logic [pts_pkg::TASK_CW-1:0]  tasks_q;
  logic [pts_pkg::TIMER_CW-1:0] timers_q;
  logic [RW-1:0]              n_q;
  logic                       pend_v_q;
  logic [HW-1:0]              pend_h_q;
  logic [HW-1:0]              res_h_q;
  logic                       res_exp_q;
  pts_pkg::pts_status_e       res_st_q;

  logic                       m_valid_q;
  logic [pts_pkg::M_DATA_W-1:0] m_data_q;
  logic                       m_last_q;

  // slot storage
  logic [CW-1:0] task_cnt_mem [NT];
  logic [CW-1:0] task_rel_mem [NT];
  logic [CW-1:0] tmr_cnt_mem  [NM];
  logic [NT-1:0] task_en_q;
  logic [NT-1:0] task_vld_q;
  logic [NM-1:0] tmr_vld_q;

  logic [CW-1:0]  task_cnt_rd_q, task_rel_rd_q, tmr_cnt_rd_q;
  logic [TIW-1:0] task_addr, task_addr_q;
  logic [MIW-1:0] tmr_addr, tmr_addr_q;
  logic [CW-1:0]  task_eff, tmr_eff;

  // handle decode
  logic           hdl_nz, task_hdl_ok, tmr_hdl_ok, tasks_full, tmrs_full;
  logic [TIW-1:0] hdl_task_idx, new_task_idx;
  logic [MIW-1:0] hdl_tmr_idx;

  // shared count unit
  pts_pkg::pts_cnt_op_t  cu_op;
  pts_pkg::pts_cnt_res_t cu_res;

  // control
  logic          out_free, due, last_task, last_tmr, n_at_max;
  logic          push, push_last, push_exp;
  logic [HW-1:0] push_h;
  logic [SW-1:0] push_st;
  logic          task_cnt_we, tmr_cnt_we_walk, step_take;
  logic          idx_inc, idx_clr;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == pts_pkg::S_IDLE);
  assign out_free      = !m_valid_q || m_axis_tready;

  assign hdl_nz       = (in_hdl != '0);
  assign task_hdl_ok  = hdl_nz && (CPW'(in_hdl) <= CPW'(tasks_q));
  assign tmr_hdl_ok   = hdl_nz && (CPW'(in_hdl) <= CPW'(timers_q));
  assign tasks_full   = (CPW'(tasks_q) >= CPW'(NT));
  assign tmrs_full    = (CPW'(timers_q) >= CPW'(NM));
  assign hdl_task_idx = TIW'(in_hdl - HW'(1));
  assign hdl_tmr_idx  = MIW'(in_hdl - HW'(1));
  assign new_task_idx = TIW'(tasks_q);

  assign task_addr = idx_q[TIW-1:0];
  assign tmr_addr  = (state_q == pts_pkg::S_IDLE) ? hdl_tmr_idx : idx_q[MIW-1:0];

  always_ff @(posedge clk_i) begin
    task_cnt_rd_q <= task_cnt_mem[task_addr];
    task_rel_rd_q <= task_rel_mem[task_addr];
    tmr_cnt_rd_q  <= tmr_cnt_mem[tmr_addr];
    task_addr_q   <= task_addr;
    tmr_addr_q    <= tmr_addr;
  end

  assign task_eff = task_vld_q[task_addr_q] ? task_cnt_rd_q : '0;
  assign tmr_eff  = tmr_vld_q[tmr_addr_q] ? tmr_cnt_rd_q : '0;

  always_comb begin
    cu_op.reload_sel = (state_q == pts_pkg::S_ST_EX);
    cu_op.reload     = task_rel_rd_q;
    if (state_q == pts_pkg::S_TM_EX || state_q == pts_pkg::S_Q_EX) begin
      cu_op.cnt = tmr_eff;
    end else begin
      cu_op.cnt = task_eff;
    end
  end

  pts_cnt_unit u_cnt (
    .op_i  (cu_op),
    .res_o (cu_res)
  );

  assign last_task = (WW'(idx_q) + WW'(1)) == WW'(tasks_q);
  assign last_tmr  = (WW'(idx_q) + WW'(1)) == WW'(timers_q);
  assign due       = task_en_q[task_addr_q] && cu_res.zero;
  assign step_take = due && (!pend_v_q || out_free);
  assign n_at_max  = (n_q + RW'(1)) == RW'(pts_pkg::MAX_RESULTS);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pts_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_func)
            pts_pkg::FN_TICK: begin
              if (tasks_q != '0) begin
                state_d = pts_pkg::S_TK_RD;
              end else if (timers_q != '0) begin
                state_d = pts_pkg::S_TM_RD;
              end else begin
                state_d = pts_pkg::S_RESP;
              end
            end
            pts_pkg::FN_STEP: begin
              state_d = (tasks_q != '0) ? pts_pkg::S_ST_RD : pts_pkg::S_ST_END;
            end
            pts_pkg::FN_QRY_TIMER: begin
              state_d = tmr_hdl_ok ? pts_pkg::S_Q_EX : pts_pkg::S_RESP;
            end
            default: state_d = pts_pkg::S_RESP;
          endcase
        end
      end
      pts_pkg::S_TK_RD: state_d = pts_pkg::S_TK_EX;
      pts_pkg::S_TK_EX: begin
        if (!last_task) begin
          state_d = pts_pkg::S_TK_RD;
        end else if (timers_q != '0) begin
          state_d = pts_pkg::S_TM_RD;
        end else begin
          state_d = pts_pkg::S_RESP;
        end
      end
      pts_pkg::S_TM_RD: state_d = pts_pkg::S_TM_EX;
      pts_pkg::S_TM_EX: state_d = last_tmr ? pts_pkg::S_RESP : pts_pkg::S_TM_RD;
      pts_pkg::S_ST_RD: state_d = pts_pkg::S_ST_EX;
      pts_pkg::S_ST_EX: begin
        if (!due || step_take) begin
          if (last_task || (due && n_at_max)) begin
            state_d = pts_pkg::S_ST_END;
          end else begin
            state_d = pts_pkg::S_ST_RD;
          end
        end
      end
      pts_pkg::S_ST_END: if (out_free) state_d = pts_pkg::S_IDLE;
      pts_pkg::S_Q_EX:   state_d = pts_pkg::S_RESP;
      pts_pkg::S_RESP:   if (out_free) state_d = pts_pkg::S_IDLE;
      default:           state_d = pts_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    push            = 1'b0;
    push_h          = '0;
    push_exp        = 1'b0;
    push_st         = SW'(pts_pkg::STAT_OK);
    push_last       = 1'b1;
    task_cnt_we     = 1'b0;
    tmr_cnt_we_walk = 1'b0;
    idx_inc         = 1'b0;
    idx_clr         = 1'b0;
    unique case (state_q)
      pts_pkg::S_IDLE: idx_clr = 1'b1;
      pts_pkg::S_TK_EX: begin
        task_cnt_we = 1'b1;
        if (last_task) begin
          idx_clr = 1'b1;
        end else begin
          idx_inc = 1'b1;
        end
      end
      pts_pkg::S_TM_EX: begin
        tmr_cnt_we_walk = 1'b1;
        idx_inc         = 1'b1;
      end
      pts_pkg::S_ST_EX: begin
        if (step_take) begin
          task_cnt_we = 1'b1;
          push        = pend_v_q;
          push_h      = pend_h_q;
          push_last   = 1'b0;
        end
        idx_inc = !due || step_take;
      end
      pts_pkg::S_ST_END: begin
        push   = out_free;
        push_h = pend_v_q ? pend_h_q : '0;
      end
      pts_pkg::S_RESP: begin
        push     = out_free;
        push_h   = res_h_q;
        push_exp = res_exp_q;
        push_st  = SW'(res_st_q);
      end
      default: ;
    endcase
  end

  // memory write ports
  always_ff @(posedge clk_i) begin
    if (task_cnt_we) begin
      task_cnt_mem[task_addr_q] <= cu_res.next;
    end
    if (accept && in_func == pts_pkg::FN_REG_TASK && !tasks_full) begin
      task_rel_mem[new_task_idx] <= in_val;
    end else if (accept && in_func == pts_pkg::FN_SET_RELD && task_hdl_ok) begin
      task_rel_mem[hdl_task_idx] <= in_val;
    end
    if (tmr_cnt_we_walk) begin
      tmr_cnt_mem[tmr_addr_q] <= cu_res.next;
    end else if (accept && in_func == pts_pkg::FN_SET_TIMER && tmr_hdl_ok) begin
      tmr_cnt_mem[hdl_tmr_idx] <= in_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_vld_q <= '0;
      tmr_vld_q  <= '0;
      task_en_q  <= '0;
    end else begin
      if (task_cnt_we) begin
        task_vld_q[task_addr_q] <= 1'b1;
      end
      if (tmr_cnt_we_walk) begin
        tmr_vld_q[tmr_addr_q] <= 1'b1;
      end else if (accept && in_func == pts_pkg::FN_SET_TIMER && tmr_hdl_ok) begin
        tmr_vld_q[hdl_tmr_idx] <= 1'b1;
      end
      if (accept && in_func == pts_pkg::FN_REG_TASK && !tasks_full) begin
        task_en_q[new_task_idx] <= in_en;
      end else if (accept && in_func == pts_pkg::FN_SET_EN && task_hdl_ok) begin
        task_en_q[hdl_task_idx] <= in_en;
      end
    end
  end

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pts_pkg::S_IDLE;
      idx_q     <= '0;
      tasks_q   <= '0;
      timers_q  <= '0;
      n_q       <= '0;
      pend_v_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (idx_clr) begin
        idx_q <= '0;
      end else if (idx_inc) begin
        idx_q <= idx_q + WW'(1);
      end
      if (accept) begin
        n_q      <= '0;
        pend_v_q <= 1'b0;
        if (in_func == pts_pkg::FN_REG_TASK && !tasks_full) begin
          tasks_q <= tasks_q + pts_pkg::TASK_CW'(1);
        end
        if (in_func == pts_pkg::FN_REG_TIMER && !tmrs_full) begin
          timers_q <= timers_q + pts_pkg::TIMER_CW'(1);
        end
      end else if (state_q == pts_pkg::S_ST_EX && step_take) begin
        n_q      <= n_q + RW'(1);
        pend_v_q <= 1'b1;
      end else if (state_q == pts_pkg::S_ST_END && out_free) begin
        pend_v_q <= 1'b0;
      end
      if (push) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pts_pkg::S_ST_EX && step_take) begin
      pend_h_q <= HW'(WW'(idx_q) + WW'(1));
    end
    if (push) begin
      m_data_q <= pts_pkg::M_DATA_W'({push_st, push_exp, push_h});
      m_last_q <= push_last;
    end
    if (state_q == pts_pkg::S_Q_EX) begin
      res_exp_q <= cu_res.zero;
    end
    if (accept) begin
      res_h_q   <= '0;
      res_exp_q <= 1'b0;
      res_st_q  <= pts_pkg::STAT_OK;
      unique case (in_func)
        pts_pkg::FN_REG_TASK: begin
          if (tasks_full) begin
            res_st_q <= pts_pkg::STAT_FULL;
          end else begin
            res_h_q <= HW'(tasks_q + pts_pkg::TASK_CW'(1));
          end
        end
        pts_pkg::FN_REG_TIMER: begin
          if (tmrs_full) begin
            res_st_q <= pts_pkg::STAT_FULL;
          end else begin
            res_h_q <= HW'(timers_q + pts_pkg::TIMER_CW'(1));
          end
        end
        pts_pkg::FN_SET_RELD, pts_pkg::FN_SET_EN: begin
          if (!task_hdl_ok) res_st_q <= pts_pkg::STAT_BADH;
        end
        pts_pkg::FN_SET_TIMER, pts_pkg::FN_QRY_TIMER: begin
          if (!tmr_hdl_ok) res_st_q <= pts_pkg::STAT_BADH;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // checks
  a_tasks_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CPW'(tasks_q) <= CPW'(NT)) else $error("task count above table size");

  a_timers_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CPW'(timers_q) <= CPW'(NM)) else $error("timer count above bank size");

  a_results_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= RW'(pts_pkg::MAX_RESULTS)) else $error("step result count overflow");

  a_pend_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> (state_q == pts_pkg::S_ST_RD || state_q == pts_pkg::S_ST_EX ||
                  state_q == pts_pkg::S_ST_END))
    else $error("pending due task outside step walk");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready) else $error("ready right after a transaction");

endmodule

/* rtl/core/pts_cnt_unit.sv */
// ----------------------------------------------------------------------------
// pts_cnt_unit
// Shared countdown unit: zero detect, decrement-to-zero and reload select.
// ----------------------------------------------------------------------------
module pts_cnt_unit (
  input  pts_pkg::pts_cnt_op_t  op_i,
  output pts_pkg::pts_cnt_res_t res_o
);

  logic zero;

  assign zero = (op_i.cnt == '0);

  always_comb begin
    res_o.zero = zero;
    if (op_i.reload_sel) begin
      res_o.next = op_i.reload;
    end else if (zero) begin
      res_o.next = '0;
    end else begin
      res_o.next = op_i.cnt - pts_pkg::COUNT_WIDTH'(1);
    end
  end

endmodule

/* tb/sched_result_checker.sv */
// ----------------------------------------------------------------------------
// sched_result_checker
// Watches both stream channels of the scheduler core. It keeps its own copy
// of the task table and timer bank, works out the replies of each accepted
// command, and compares every reply transaction field by field with the
// oldest reply still awaited. It reports the failure count and the number of
// replies still awaited.
// ----------------------------------------------------------------------------
module sched_result_checker
  import pts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // handle, value, enable, zero pad
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // func
  input  logic [FUNC_W-1:0]   s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // result_handle, expired, status
  input  logic [M_DATA_W-1:0] m_axis_tdata,
  input  logic                m_axis_tlast,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         compared_o
);

  typedef struct packed {
    logic [HANDLE_W-1:0] hnd;
    logic                expired;
    pts_status_e         status;
    logic                last;
  } sched_reply_t;

  logic [COUNT_WIDTH-1:0] reload_val [NUM_TASKS];
  logic [COUNT_WIDTH-1:0] task_cnt   [NUM_TASKS];
  logic                   task_on    [NUM_TASKS];
  logic [COUNT_WIDTH-1:0] timer_cnt  [NUM_TIMERS];
  int unsigned            n_tasks;
  int unsigned            n_timers;
  sched_reply_t           awaited_replies [$];
  int unsigned            fails;
  int unsigned            compared;

  initial begin
    fails        = 0;
    compared     = 0;
    fail_count_o = 0;
    pending_o    = 0;
    compared_o   = 0;
  end

  function automatic void add_reply(int unsigned hnd, logic expired, pts_status_e status,
                                    logic last);
    sched_reply_t r;
    r.hnd     = hnd[HANDLE_W-1:0];
    r.expired = expired;
    r.status  = status;
    r.last    = last;
    awaited_replies.push_back(r);
  endfunction

  function automatic void run_command(pts_func_e fn, logic [HANDLE_W-1:0] hnd,
                                      logic [VALUE_W-1:0] val, logic en);
    int unsigned            due_total;
    int unsigned            k;
    logic [COUNT_WIDTH-1:0] cnt;
    cnt = val[COUNT_WIDTH-1:0];
    due_total = 0;
    k = 0;
    case (fn)
      FN_TICK: begin
        for (int i = 0; i < n_tasks; i++)
          if (task_cnt[i] != '0) task_cnt[i] = task_cnt[i] - 1'b1;
        for (int i = 0; i < n_timers; i++)
          if (timer_cnt[i] != '0) timer_cnt[i] = timer_cnt[i] - 1'b1;
        add_reply(0, 1'b0, STAT_OK, 1'b1);
      end
      FN_STEP: begin
        for (int i = 0; i < n_tasks; i++)
          if (task_on[i] && task_cnt[i] == '0) due_total++;
        if (due_total > MAX_RESULTS) due_total = MAX_RESULTS;
        if (due_total == 0) begin
          add_reply(0, 1'b0, STAT_OK, 1'b1);
        end else begin
          for (int i = 0; i < n_tasks && k < due_total; i++) begin
            if (task_on[i] && task_cnt[i] == '0) begin
              task_cnt[i] = reload_val[i];
              k++;
              add_reply(i + 1, 1'b0, STAT_OK, k == due_total);
            end
          end
        end
      end
      FN_REG_TASK: begin
        if (n_tasks >= NUM_TASKS) begin
          add_reply(0, 1'b0, STAT_FULL, 1'b1);
        end else begin
          reload_val[n_tasks] = cnt;
          task_on[n_tasks]    = en;
          n_tasks++;
          add_reply(n_tasks, 1'b0, STAT_OK, 1'b1);
        end
      end
      FN_SET_RELD, FN_SET_EN: begin
        if (hnd == '0 || hnd > n_tasks) begin
          add_reply(0, 1'b0, STAT_BADH, 1'b1);
        end else begin
          if (fn == FN_SET_RELD) reload_val[hnd - 1] = cnt;
          else task_on[hnd - 1] = en;
          add_reply(0, 1'b0, STAT_OK, 1'b1);
        end
      end
      FN_REG_TIMER: begin
        if (n_timers >= NUM_TIMERS) begin
          add_reply(0, 1'b0, STAT_FULL, 1'b1);
        end else begin
          n_timers++;
          add_reply(n_timers, 1'b0, STAT_OK, 1'b1);
        end
      end
      default: begin
        if (hnd == '0 || hnd > n_timers) begin
          add_reply(0, 1'b0, STAT_BADH, 1'b1);
        end else if (fn == FN_SET_TIMER) begin
          timer_cnt[hnd - 1] = cnt;
          add_reply(0, 1'b0, STAT_OK, 1'b1);
        end else begin
          add_reply(0, timer_cnt[hnd - 1] == '0, STAT_OK, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        reload_val[i] = '0;
        task_cnt[i]   = '0;
        task_on[i]    = 1'b0;
      end
      for (int i = 0; i < NUM_TIMERS; i++) timer_cnt[i] = '0;
      n_tasks  = 0;
      n_timers = 0;
      awaited_replies.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_replies.size() == 0) begin
          fails++;
          $display("%0t: unexpected reply, expected none, actual tdata %h tlast %b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = awaited_replies.pop_front();
          compared++;
          check_field("result_handle", want.hnd, m_axis_tdata[HANDLE_W-1:0]);
          check_field("expired", want.expired, m_axis_tdata[HANDLE_W]);
          check_field("status", want.status, m_axis_tdata[HANDLE_W+STATUS_W:HANDLE_W+1]);
          check_field("last", want.last, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        run_command(pts_func_e'(s_axis_tuser), s_axis_tdata[HANDLE_W-1:0],
                    s_axis_tdata[HANDLE_W+VALUE_W-1:HANDLE_W], s_axis_tdata[HANDLE_W+VALUE_W]);
    end
    pending_o    <= awaited_replies.size();
    fail_count_o <= fails;
    compared_o   <= compared;
  end

endmodule

/* tb/tb_periodic_task_and_timer_scheduler_core.sv */
// ----------------------------------------------------------------------------
// tb_periodic_task_and_timer_scheduler_core
// Drives commands into the scheduler core: a directed opening over empty
// tables, zero and maximum reloads, bad handles and timer expiry, then a fill
// of both tables past full, then random tick/step and timer sequences mixed
// with noise. Both sides idle at random, the receiver holds off once for a
// long stretch, and a separate checker compares every reply.
// ----------------------------------------------------------------------------
module tb_periodic_task_and_timer_scheduler_core;
  import pts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned TOTAL_ITEMS = 170;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [FUNC_W-1:0]   s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned compared;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned tasks_sent = 0;
  int unsigned timers_sent = 0;
  int unsigned func_hits [8];
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          hold_req = 1'b0;

  periodic_task_and_timer_scheduler_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  sched_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .compared_o    (compared)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [VALUE_W-1:0] draw_count();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return $urandom_range(0, 4);
    if (roll == 7) return '1;
    return $urandom;
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle(int unsigned count);
    logic [HANDLE_W-1:0] h;
    if (count == 0 || $urandom_range(0, 99) < 12) h = $urandom_range(0, 31);
    else h = $urandom_range(1, count);
    return h;
  endfunction

  task automatic send(pts_func_e fn, logic [HANDLE_W-1:0] hnd, logic [VALUE_W-1:0] val,
                      logic en);
    int unsigned         gap;
    logic [S_DATA_W-1:0] word;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word = '0;
    word[HANDLE_W-1:0] = hnd;
    word[HANDLE_W+VALUE_W-1:HANDLE_W] = val;
    word[HANDLE_W+VALUE_W] = en;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= fn;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    func_hits[fn]++;
    if (fn == FN_REG_TASK && tasks_sent < NUM_TASKS) tasks_sent++;
    if (fn == FN_REG_TIMER && timers_sent < NUM_TIMERS) timers_sent++;
    sent++;
    if (sent % 16 == 0) tx_idle = ($urandom_range(0, 3) != 0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls per reply, one long hold-off on request
  initial begin
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = rx_idle ? $urandom_range(0, 14) : 0;
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      taken++;
      if (taken % 16 == 0) rx_idle = ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    int unsigned        roll;
    logic [HANDLE_W-1:0] h;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty tables
    send(FN_STEP, 0, 0, 0);
    send(FN_TICK, 0, 0, 0);
    send(FN_QRY_TIMER, 0, 0, 0);
    send(FN_SET_RELD, 1, 5, 0);
    send(FN_SET_TIMER, 1, 3, 0);
    // zero reload, maximum reload disabled, short reload
    send(FN_REG_TASK, 0, 0, 1);
    send(FN_REG_TASK, 31, '1, 0);
    send(FN_REG_TASK, 0, 2, 1);
    send(FN_STEP, 0, 0, 0);
    send(FN_STEP, 0, 0, 0);
    send(FN_TICK, 0, 0, 0);
    send(FN_TICK, 0, 0, 0);
    send(FN_STEP, 0, 0, 0);
    send(FN_SET_EN, 2, '1, 1);
    send(FN_STEP, 0, 0, 0);
    send(FN_SET_RELD, 4, 7, 1);
    send(FN_SET_EN, 31, 0, 0);
    // one-shot timer expiry
    send(FN_REG_TIMER, 0, 0, 0);
    send(FN_SET_TIMER, 1, 1, 1);
    send(FN_QRY_TIMER, 1, 0, 0);
    send(FN_TICK, 0, 0, 0);
    send(FN_QRY_TIMER, 1, 0, 0);
    send(FN_SET_TIMER, 1, '1, 0);
    send(FN_QRY_TIMER, 2, 0, 0);
    send(FN_QRY_TIMER, 1, 0, 0);
    wait_drained();

    // fill both tables, then one more of each
    while (tasks_sent < NUM_TASKS || timers_sent < NUM_TIMERS) begin
      if (timers_sent >= NUM_TIMERS || (tasks_sent < NUM_TASKS && $urandom_range(0, 1) == 0))
        send(FN_REG_TASK, $urandom, draw_count(), $urandom_range(0, 3) != 0);
      else
        send(FN_REG_TIMER, $urandom, $urandom, $urandom);
    end
    send(FN_REG_TASK, $urandom, $urandom, $urandom);
    send(FN_REG_TIMER, $urandom, $urandom, $urandom);

    // most new tasks are due: long receiver hold-off while commands keep coming
    hold_req = 1'b1;
    send(FN_STEP, 0, 0, 0);

    while (sent < TOTAL_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        repeat ($urandom_range(1, 3)) send(FN_TICK, $urandom, $urandom, $urandom);
        send(FN_STEP, $urandom, $urandom, $urandom);
      end else if (roll < 50) begin
        h = pick_handle(timers_sent);
        send(FN_SET_TIMER, h, draw_count(), $urandom);
        repeat ($urandom_range(0, 2)) send(FN_TICK, 0, 0, 0);
        send(FN_QRY_TIMER, h, $urandom, $urandom);
      end else if (roll < 60) begin
        send(FN_SET_RELD, pick_handle(tasks_sent), draw_count(), $urandom);
      end else if (roll < 70) begin
        send(FN_SET_EN, pick_handle(tasks_sent), $urandom, $urandom);
      end else if (roll < 75) begin
        send(roll[0] ? FN_REG_TASK : FN_REG_TIMER, $urandom, $urandom, $urandom);
      end else if (roll < 90) begin
        send(pts_func_e'($urandom_range(0, 7)), $urandom_range(0, 31), $urandom, $urandom);
      end else begin
        send(FN_QRY_TIMER, pick_handle(timers_sent), $urandom, $urandom);
      end
      if (sent >= 110 && sent < 114) wait_drained();
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run covered %0d commands: %0d ticks, %0d steps, %0d task and %0d timer registers",
             sent, func_hits[FN_TICK], func_hits[FN_STEP], func_hits[FN_REG_TASK],
             func_hits[FN_REG_TIMER]);
    $display("%0d replies compared, including full tables, bad handles and a long output stall",
             compared);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* periodic_task_and_timer_scheduler_core.f */
rtl/core/pts_pkg.sv
rtl/core/pts_cnt_unit.sv
rtl/core/periodic_task_and_timer_scheduler_core.sv
tb/sched_result_checker.sv
tb/tb_periodic_task_and_timer_scheduler_core.sv
